// ===== rtl/core/gsp_pkg.sv =====
package gsp_pkg;

   localparam int COORD_WIDTH = 4;
   localparam int MOVE_WIDTH  = 3;
   localparam int DIR_COUNT   = 4;

   localparam int DIR_UP    = 0;
   localparam int DIR_DOWN  = 1;
   localparam int DIR_LEFT  = 2;
   localparam int DIR_RIGHT = 3;

   typedef logic [COORD_WIDTH-1:0] coord_type;
   typedef logic [MOVE_WIDTH-1:0]  move_type;
   typedef logic [DIR_COUNT-1:0]   dir_vec_type;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam move_type MOVE_NONE  = 3'd0;
   localparam move_type MOVE_UP    = 3'd1;
   localparam move_type MOVE_DOWN  = 3'd2;
   localparam move_type MOVE_LEFT  = 3'd3;
   localparam move_type MOVE_RIGHT = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLOOD,
      ST_DONE
   } gsp_state_type;

   typedef struct packed {
      logic load;
      logic flood;
   } gsp_ctrl_type;

endpackage

// ===== rtl/core/gsp_cell.sv =====
module gsp_cell import gsp_pkg::*; #(
   parameter int ROW = 0,
   parameter int COL = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  gsp_ctrl_type ctrl,
   input  logic         wr_en,
   input  coord_type    wr_x,
   input  coord_type    wr_y,
   input  logic         wr_wall,
   input  coord_type    start_x,
   input  coord_type    start_y,
   input  coord_type    target_x,
   input  coord_type    target_y,
   input  dir_vec_type  nbr_vis,
   output logic         vis,
   output dir_vec_type  hit
);

   logic        wall_ff, wall_in;
   logic        vis_ff, vis_in;
   dir_vec_type nbr_ff, nbr_in;
   logic        is_target;
   logic        wr_match;

   assign wr_match  = wr_en && (int'(wr_x) == COL) && (int'(wr_y) == ROW);
   assign is_target = (int'(target_x) == COL) && (int'(target_y) == ROW);

   always_comb begin
      wall_in = wr_match ? wr_wall : wall_ff;

      nbr_in = nbr_ff;
      if (ctrl.load) begin
         nbr_in[DIR_UP]    = (int'(start_x) == COL) && (int'(start_y) == ROW + 1);
         nbr_in[DIR_DOWN]  = (int'(start_x) == COL) && (int'(start_y) == ROW - 1);
         nbr_in[DIR_LEFT]  = (int'(start_y) == ROW) && (int'(start_x) == COL + 1);
         nbr_in[DIR_RIGHT] = (int'(start_y) == ROW) && (int'(start_x) == COL - 1);
      end

      vis_in = vis_ff;
      if (ctrl.load) begin
         vis_in = is_target && !wall_ff;
      end else if (ctrl.flood) begin
         vis_in = vis_ff || (!wall_ff && (|nbr_vis));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_ff <= 1'b0;
      end else begin
         wall_ff <= wall_in;
      end
   end

   always_ff @(posedge clock) begin
      vis_ff <= vis_in;
      nbr_ff <= nbr_in;
   end

   assign vis = vis_ff;
   assign hit = nbr_ff & {DIR_COUNT{vis_ff}};

endmodule

// ===== rtl/core/gsp_seq.sv =====
module gsp_seq import gsp_pkg::*; #(
   parameter int CELL_COUNT = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         query_accept,
   input  logic         zero_case,
   input  dir_vec_type  dir_hit,
   input  logic         rsp_ready,
   output gsp_ctrl_type ctrl,
   output logic         req_ready,
   output logic         rsp_valid,
   output move_type     rsp_move
);

   localparam int CNT_W = $clog2(CELL_COUNT + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CELL_COUNT);

   gsp_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   move_type         move_ff, move_in;
   logic             rsp_valid_ff, rsp_valid_in;
   move_type         rsp_move_ff, rsp_move_in;
   logic             rsp_load;
   move_type         pick;

   always_comb begin
      if (dir_hit[DIR_UP]) begin
         pick = MOVE_UP;
      end else if (dir_hit[DIR_DOWN]) begin
         pick = MOVE_DOWN;
      end else if (dir_hit[DIR_LEFT]) begin
         pick = MOVE_LEFT;
      end else if (dir_hit[DIR_RIGHT]) begin
         pick = MOVE_RIGHT;
      end else begin
         pick = MOVE_NONE;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_accept) begin
               state_in = zero_case ? ST_DONE : ST_FLOOD;
            end
         end
         ST_FLOOD: begin
            if ((|dir_hit) || (count_ff == CNT_LIMIT)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      ctrl.load  = 1'b0;
      ctrl.flood = 1'b0;
      rsp_load   = 1'b0;
      count_in   = count_ff;
      move_in    = move_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = query_accept;
            count_in  = '0;
            move_in   = MOVE_NONE;
         end
         ST_FLOOD: begin
            ctrl.flood = 1'b1;
            count_in   = count_ff + 1'b1;
            move_in    = pick;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_move_in  = rsp_load ? move_ff : rsp_move_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      move_ff     <= move_in;
      rsp_move_ff <= rsp_move_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_move  = rsp_move_ff;

endmodule

// ===== rtl/core/grid_shortest_path_first_move.sv =====
// A write transaction (opcode 0) updates one wall cell and produces no
// response. A query transaction (opcode 1) loads a wavefront at the target
// into a GRID_SIDE by GRID_SIDE array of cells; each cycle the wavefront
// spreads one step into open neighboring cells, and the first step is the
// start neighbor reached earliest, ties broken up, down, left, right.
// An unreachable target or a walled target ends the query when the
// wavefront step counter reaches its limit. Queries with equal start and
// target or with a cell outside the grid answer without a flood. The wall
// map is cleared by reset. One transaction is processed at a time, and a
// new transaction may be accepted while the previous response waits in the
// output register.
module grid_shortest_path_first_move import gsp_pkg::*; #(
   parameter int GRID_SIDE = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic      req_opcode,
   input  coord_type req_cell_x,
   input  coord_type req_cell_y,
   input  logic      req_is_wall,
   input  coord_type req_start_x,
   input  coord_type req_start_y,
   input  coord_type req_target_x,
   input  coord_type req_target_y,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output move_type  rsp_move
);

   localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;

   gsp_ctrl_type ctrl;
   logic         wr_en;
   logic         query_accept;
   logic         zero_case;
   logic         vis [GRID_SIDE][GRID_SIDE];
   dir_vec_type  hit [GRID_SIDE][GRID_SIDE];
   dir_vec_type  row_hit_in [GRID_SIDE];
   dir_vec_type  row_hit_ff [GRID_SIDE];
   dir_vec_type  dir_hit;

   assign wr_en        = req_valid && req_ready && (req_opcode == OP_WRITE);
   assign query_accept = req_valid && req_ready && (req_opcode == OP_QUERY);

   assign zero_case = (int'(req_start_x) >= GRID_SIDE) || (int'(req_start_y) >= GRID_SIDE)
                   || (int'(req_target_x) >= GRID_SIDE) || (int'(req_target_y) >= GRID_SIDE)
                   || ((req_start_x == req_target_x) && (req_start_y == req_target_y));

   for (genvar r = 0; r < GRID_SIDE; r++) begin : g_row
      for (genvar c = 0; c < GRID_SIDE; c++) begin : g_col
         dir_vec_type nv;
         logic        cell_vis;

         if (r > 0) begin : g_up
            assign nv[DIR_UP] = vis[r-1][c];
         end else begin : g_up_edge
            assign nv[DIR_UP] = 1'b0;
         end
         if (r < GRID_SIDE - 1) begin : g_down
            assign nv[DIR_DOWN] = vis[r+1][c];
         end else begin : g_down_edge
            assign nv[DIR_DOWN] = 1'b0;
         end
         if (c > 0) begin : g_left
            assign nv[DIR_LEFT] = vis[r][c-1];
         end else begin : g_left_edge
            assign nv[DIR_LEFT] = 1'b0;
         end
         if (c < GRID_SIDE - 1) begin : g_right
            assign nv[DIR_RIGHT] = vis[r][c+1];
         end else begin : g_right_edge
            assign nv[DIR_RIGHT] = 1'b0;
         end

         gsp_cell #(
            .ROW (r),
            .COL (c)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .wr_en    (wr_en),
            .wr_x     (req_cell_x),
            .wr_y     (req_cell_y),
            .wr_wall  (req_is_wall),
            .start_x  (req_start_x),
            .start_y  (req_start_y),
            .target_x (req_target_x),
            .target_y (req_target_y),
            .nbr_vis  (nv),
            .vis      (cell_vis),
            .hit      (hit[r][c])
         );

         assign vis[r][c] = cell_vis;
      end
   end

   always_comb begin
      for (int r = 0; r < GRID_SIDE; r++) begin
         row_hit_in[r] = '0;
         for (int c = 0; c < GRID_SIDE; c++) begin
            row_hit_in[r] = row_hit_in[r] | hit[r][c];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < GRID_SIDE; r++) begin
         row_hit_ff[r] <= ctrl.load ? '0 : row_hit_in[r];
      end
   end

   always_comb begin
      dir_hit = '0;
      for (int r = 0; r < GRID_SIDE; r++) begin
         dir_hit = dir_hit | row_hit_ff[r];
      end
   end

   gsp_seq #(
      .CELL_COUNT (CELL_COUNT)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .query_accept (query_accept),
      .zero_case    (zero_case),
      .dir_hit      (dir_hit),
      .rsp_ready    (rsp_ready),
      .ctrl         (ctrl),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_move     (rsp_move)
   );

endmodule
